// ----- src/bfem_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfem_pkg - shared definitions of the 3x3 edge mean box filter
// Register map, field widths and the reciprocal table of the divide unit.
// ----------------------------------------------------------------------------
package bfem_pkg;

    // register indexes (byte address 4*index)
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // reset geometry
    localparam logic [7:0] FRAME_WIDTH_RST  = 8'd80;
    localparam logic [6:0] FRAME_HEIGHT_RST = 7'd21;

    // field widths
    localparam int VALUE_W = 8;
    localparam int ROW_W   = 6;
    localparam int COL_W   = 7;
    localparam int SUM_W   = 12;
    localparam int RECIP_W = 17;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W  = SUM_W + RECIP_W;

    // ceil(2^16 / n) for neighbour counts 1 to 9
    function automatic logic [RECIP_W-1:0] recip(input logic [3:0] n);
        logic [RECIP_W-1:0] m;
        unique case (n)
            4'd1:    m = 17'd65536;
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd5:    m = 17'd13108;
            4'd6:    m = 17'd10923;
            4'd7:    m = 17'd9363;
            4'd8:    m = 17'd8192;
            4'd9:    m = 17'd7282;
            default: m = 17'd0;
        endcase
        return m;
    endfunction

endpackage

// ----- src/box_filter_3x3_edge_mean_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_3x3_edge_mean_top - streaming 3x3 mean filter with edge handling
// Raster-order cells in, floored means of the in-frame 3x3 neighbourhood out.
// ----------------------------------------------------------------------------
//  channel   dir  signals                                   content
//  s_*       in   tvalid tready tdata[7:0]                  cell value
//  m_*       out  tvalid tready tdata[23:0] tlast           row, col, mean, last
//  apb       in   psel penable pwrite paddr[2:0] pwdata     frame geometry
//
//  an input transfer is accepted (line store read), then written back, then its
//  results (0 to 4) are given one at a time before the next cell is taken, set by
//  the single read-modify-write port pair of the line stores and the shared divide unit
//  results leave through a two-stage pipe (sum, then reciprocal multiply)
//  a stall on m_* holds the pipe and then the result sequencer
//  rst_n clears control and geometry; the line stores are not cleared
// ----------------------------------------------------------------------------
module box_filter_3x3_edge_mean_top #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] cell_value
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [5:0] out_row, [12:6] out_col, [20:13] smoothed
    output logic        m_tlast,    // last_of_run
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_GEN} state_t;

    // configuration registers
    logic [7:0] frame_width_reg;
    logic [6:0] frame_height_reg;

    // control
    state_t        state_reg;
    logic [CW-1:0] col_count_reg;
    logic [RW-1:0] row_count_reg;
    logic [CW-1:0] c_reg;
    logic [RW-1:0] r_reg;
    logic [3:0]    mask_reg;
    logic [7:0]    val_reg;

    // line stores
    logic [7:0] above_mem [MAX_WIDTH];
    logic [7:0] current_mem [MAX_WIDTH];
    logic [7:0] top_rd_reg;
    logic [7:0] mid_rd_reg;

    // window: [column c-2, c-1, c][row r-2, r-1, r]
    logic [7:0] win_reg [3][3];

    // result pipe
    logic                         a_valid_reg;
    logic [bfem_pkg::SUM_W-1:0]   a_sum_reg;
    logic [bfem_pkg::RECIP_W-1:0] a_recip_reg;
    logic [bfem_pkg::ROW_W-1:0]   a_row_reg;
    logic [bfem_pkg::COL_W-1:0]   a_col_reg;
    logic                         a_last_reg;
    logic                         out_valid_reg;
    logic [23:0]                  out_data_reg;
    logic                         out_last_reg;

    logic in_xfer;
    logic cfg_wr;
    logic [CW-1:0] wlast;
    logic [RW-1:0] hlast;
    logic [CW-1:0] c_cur;
    logic [RW-1:0] r_cur;
    logic [3:0] mask_init;
    logic [1:0] gen_k;
    logic [3:0] mask_next;
    logic gen_last;
    logic gen_fire;
    logic a_free;
    logic b_free;
    logic [2:0] vmask;
    logic [2:0] hmask;
    logic [1:0] vcnt;
    logic [1:0] hcnt;
    logic [3:0] ncnt;
    logic [bfem_pkg::SUM_W-1:0] win_sum;
    logic [RW-1:0] gen_row;
    logic [CW-1:0] gen_col;
    logic [bfem_pkg::PROD_W-1:0] prod;

    assign in_xfer  = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= bfem_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= bfem_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == bfem_pkg::REG_FRAME_WIDTH)
                frame_width_reg <= pwdata[7:0];
            else
                frame_height_reg <= pwdata[6:0];
        end
    end

    // register read
    always_comb
    begin
        if (paddr[2] == bfem_pkg::REG_FRAME_WIDTH)
            prdata = {24'd0, frame_width_reg};
        else
            prdata = {25'd0, frame_height_reg};
    end

    // clamped geometry, last column and last row
    always_comb
    begin
        if (frame_width_reg == 8'd0)
            wlast = '0;
        else if (32'(frame_width_reg) > MAX_WIDTH)
            wlast = CW'(MAX_WIDTH - 1);
        else
            wlast = CW'(frame_width_reg - 8'd1);
        if (frame_height_reg == 7'd0)
            hlast = '0;
        else if (32'(frame_height_reg) > MAX_HEIGHT)
            hlast = RW'(MAX_HEIGHT - 1);
        else
            hlast = RW'(frame_height_reg - 7'd1);
    end

    // position of the incoming cell, held to the last row and column
    assign c_cur = (col_count_reg > wlast) ? wlast : col_count_reg;
    assign r_cur = (row_count_reg > hlast) ? hlast : row_count_reg;

    // results to give: bit {v,h}, v/h = 0 for centre one back, 1 for the edge case
    always_comb
    begin
        logic [1:0] v_en;
        logic [1:0] h_en;
        v_en = {(r_reg == hlast), (r_reg != '0)};
        h_en = {(c_reg == wlast), (c_reg != '0)};
        mask_init = {v_en[1] & h_en[1], v_en[1] & h_en[0],
                     v_en[0] & h_en[1], v_en[0] & h_en[0]};
    end

    // lowest pending result
    always_comb
    begin
        priority if (mask_reg[0]) gen_k = 2'd0;
        else if (mask_reg[1])     gen_k = 2'd1;
        else if (mask_reg[2])     gen_k = 2'd2;
        else                      gen_k = 2'd3;
        mask_next = mask_reg & ~(4'd1 << gen_k);
        gen_last  = (mask_next == 4'd0);
    end

    assign b_free   = !out_valid_reg || m_tready;
    assign a_free   = !a_valid_reg || b_free;
    assign gen_fire = (state_reg == ST_GEN) && a_free;

    // sequencer, position counters and latched position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_count_reg <= '0;
            row_count_reg <= '0;
            c_reg         <= '0;
            r_reg         <= '0;
            mask_reg      <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        c_reg     <= c_cur;
                        r_reg     <= r_cur;
                        state_reg <= ST_LOAD;
                        if (c_cur >= wlast)
                        begin
                            col_count_reg <= '0;
                            row_count_reg <= (r_cur >= hlast) ? '0 : r_cur + RW'(1);
                        end
                        else
                        begin
                            col_count_reg <= c_cur + CW'(1);
                            row_count_reg <= r_cur;
                        end
                    end
                end
                ST_LOAD:
                begin
                    mask_reg  <= mask_init;
                    state_reg <= (mask_init == 4'd0) ? ST_IDLE : ST_GEN;
                end
                ST_GEN:
                begin
                    if (gen_fire)
                    begin
                        mask_reg <= mask_next;
                        if (gen_last)
                            state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // cell capture
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            val_reg <= s_tdata;
    end

    // line store two rows back: read on transfer, write back the middle row value
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
            above_mem[c_reg] <= mid_rd_reg;
        if (in_xfer)
            top_rd_reg <= above_mem[c_cur];
    end

    // line store one row back: read on transfer, write back the new cell
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
            current_mem[c_reg] <= val_reg;
        if (in_xfer)
            mid_rd_reg <= current_mem[c_cur];
    end

    // window shift
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            win_reg[0]    <= win_reg[1];
            win_reg[1]    <= win_reg[2];
            win_reg[2][0] <= top_rd_reg;
            win_reg[2][1] <= mid_rd_reg;
            win_reg[2][2] <= val_reg;
        end
    end

    // in-frame neighbours of the selected centre
    always_comb
    begin
        vmask[0] = gen_k[1] ? 1'b0 : (r_reg >= RW'(2)) && (RW >= 2);
        vmask[1] = (r_reg != '0);
        vmask[2] = 1'b1;
        hmask[0] = gen_k[0] ? 1'b0 : (c_reg >= CW'(2)) && (CW >= 2);
        hmask[1] = (c_reg != '0);
        hmask[2] = 1'b1;
        vcnt = 2'(vmask[0]) + 2'(vmask[1]) + 2'(vmask[2]);
        hcnt = 2'(hmask[0]) + 2'(hmask[1]) + 2'(hmask[2]);
        ncnt = 4'(vcnt) * 4'(hcnt);
    end

    // neighbourhood sum
    always_comb
    begin
        win_sum = '0;
        for (int h = 0; h < 3; h++)
        begin
            for (int v = 0; v < 3; v++)
            begin
                if (hmask[h] && vmask[v])
                    win_sum = win_sum + bfem_pkg::SUM_W'(win_reg[h][v]);
            end
        end
    end

    // position of the selected centre
    assign gen_row = gen_k[1] ? r_reg : r_reg - RW'(1);
    assign gen_col = gen_k[0] ? c_reg : c_reg - CW'(1);

    // stage a: sum and reciprocal
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (a_free)
            a_valid_reg <= gen_fire;
    end

    always_ff @(posedge clk)
    begin
        if (gen_fire)
        begin
            a_sum_reg   <= win_sum;
            a_recip_reg <= bfem_pkg::recip(ncnt);
            a_row_reg   <= bfem_pkg::ROW_W'(gen_row);
            a_col_reg   <= bfem_pkg::COL_W'(gen_col);
            a_last_reg  <= gen_last;
        end
    end

    // stage b: reciprocal multiply into the output register
    assign prod = bfem_pkg::PROD_W'(a_sum_reg) * bfem_pkg::PROD_W'(a_recip_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (b_free)
            out_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b_free && a_valid_reg)
        begin
            out_data_reg <= {3'd0,
                             prod[bfem_pkg::RECIP_SHIFT +: bfem_pkg::VALUE_W],
                             a_col_reg, a_row_reg};
            out_last_reg <= a_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // an accepted cell is always followed by its write-back cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_LOAD))
        else $error("write-back cycle missing after input transfer");

    // the sequencer only runs with results pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GEN) |-> (mask_reg != 4'd0))
        else $error("result sequencer running with nothing pending");

    // the last result of a run returns the sequencer to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (gen_fire && gen_last) |=> (state_reg == ST_IDLE) && a_valid_reg && a_last_reg)
        else $error("last result not marked or sequencer not idle");

    // a result in stage a always has a neighbour count of 1 to 9
    assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> (a_recip_reg != '0))
        else $error("empty neighbourhood reached the divide unit");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the 3x3 edge mean box filter
// Streams frames of cell values through the block under random valid and
// ready gaps, predicts every smoothed cell with a local line-store model,
// and checks each output transfer in order, field by field. Geometry is
// set over the register port between phases, including clamped values.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_W         = 128;
    localparam int MAX_H         = 64;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_CELLS  = 260;

    typedef struct packed {
        logic [bfem_pkg::ROW_W-1:0]   row;
        logic [bfem_pkg::COL_W-1:0]   col;
        logic [bfem_pkg::VALUE_W-1:0] mean;
        logic                         last;
    } mean_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;      // [7:0] cell_value
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;      // [5:0] out_row, [12:6] out_col, [20:13] smoothed
    logic        m_tlast;      // last_of_run
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // bench control shared between processes
    mean_result_t expected_means [$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    int           random_cells   = 0;
    int           ready_holdoff  = 0;
    bit           sender_idles   = 1'b1;
    bit           receiver_idles = 1'b1;

    // local copy of the filter state
    logic [7:0]  cfg_width;
    logic [6:0]  cfg_height;
    logic [7:0]  above_line   [MAX_W];
    logic [7:0]  current_line [MAX_W];
    bit          above_seen   [MAX_W];
    bit          current_seen [MAX_W];
    int unsigned pos_row;
    int unsigned pos_col;
    int unsigned win [3][3];   // [column c-2..c][row r-2..r]

    box_filter_3x3_edge_mean_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock, 8 ns period
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic note_failure(input string msg);
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    function automatic int unsigned eff_width(input logic [7:0] reg_w);
        if (reg_w == 8'd0)
            return 1;
        if (reg_w > MAX_W)
            return MAX_W;
        return reg_w;
    endfunction

    function automatic int unsigned eff_height(input logic [6:0] reg_h);
        if (reg_h == 7'd0)
            return 1;
        if (reg_h > MAX_H)
            return MAX_H;
        return reg_h;
    endfunction

    task automatic clear_filter_state();
        cfg_width  = bfem_pkg::FRAME_WIDTH_RST;
        cfg_height = bfem_pkg::FRAME_HEIGHT_RST;
        pos_row    = 0;
        pos_col    = 0;
        for (int k = 0; k < MAX_W; k++)
        begin
            above_line[k]   = 8'd0;
            current_line[k] = 8'd0;
            above_seen[k]   = 1'b0;
            current_seen[k] = 1'b0;
        end
        for (int k = 0; k < 9; k++)
            win[k / 3][k % 3] = 0;
    endtask

    // mean of the in-frame cells around window centre (vc, hc) at input (r, c)
    function automatic logic [7:0] neighbourhood_mean(input int unsigned r, input int unsigned c,
                                                      input int unsigned vc, input int unsigned hc);
        int unsigned sum;
        int unsigned n;
        int unsigned vi;
        int unsigned hi;
        sum = 0;
        n   = 0;
        for (int dv = 0; dv < 3; dv++)
        begin
            vi = vc + dv - 1;
            if (vi > 2 || r + vi < 2)
                continue;
            for (int dh = 0; dh < 3; dh++)
            begin
                hi = hc + dh - 1;
                if (hi > 2 || c + hi < 2)
                    continue;
                sum = sum + win[hi][vi];
                n   = n + 1;
            end
        end
        return (n != 0) ? 8'(sum / n) : 8'd0;
    endfunction

    // advance the filter by one cell and queue the means it completes
    task automatic smooth_cell(input logic [7:0] value);
        int unsigned  w;
        int unsigned  h;
        int unsigned  r;
        int unsigned  c;
        int unsigned  top;
        int unsigned  mid;
        int unsigned  vcs [2];
        int unsigned  hcs [2];
        int           nv;
        int           nh;
        int           coord;
        mean_result_t res;
        w   = eff_width(cfg_width);
        h   = eff_height(cfg_height);
        r   = (pos_row < h - 1) ? pos_row : h - 1;
        c   = (pos_col < w - 1) ? pos_col : w - 1;
        top = above_line[c];
        mid = current_line[c];

        // line stores and their written marks
        above_line[c]   = mid[7:0];
        current_line[c] = value;
        above_seen[c]   = current_seen[c];
        current_seen[c] = 1'b1;

        // slide the window one column
        for (int k = 0; k < 3; k++)
        begin
            win[0][k] = win[1][k];
            win[1][k] = win[2][k];
        end
        win[2][0] = top;
        win[2][1] = mid;
        win[2][2] = value;

        // centres completed by this cell, bottom and right edges add a second
        nv = 0;
        nh = 0;
        if (r >= 1)
        begin
            vcs[nv] = 1;
            nv = nv + 1;
        end
        if (r == h - 1)
        begin
            vcs[nv] = 2;
            nv = nv + 1;
        end
        if (c >= 1)
        begin
            hcs[nh] = 1;
            nh = nh + 1;
        end
        if (c == w - 1)
        begin
            hcs[nh] = 2;
            nh = nh + 1;
        end
        for (int i = 0; i < nv; i++)
        begin
            for (int j = 0; j < nh; j++)
            begin
                coord    = r + vcs[i] - 2;
                res.row  = coord[bfem_pkg::ROW_W-1:0];
                coord    = c + hcs[j] - 2;
                res.col  = coord[bfem_pkg::COL_W-1:0];
                res.mean = neighbourhood_mean(r, c, vcs[i], hcs[j]);
                res.last = (i == nv - 1) && (j == nh - 1);
                expected_means.push_back(res);
            end
        end

        // position counters, wrapping after the last cell
        if (c >= w - 1)
        begin
            pos_col = 0;
            pos_row = (r >= h - 1) ? 0 : r + 1;
        end
        else
        begin
            pos_col = c + 1;
            pos_row = r;
        end
    endtask

    // a width may change mid-frame only where both line stores hold written data
    function automatic bit width_is_safe(input logic [7:0] reg_w);
        int unsigned w;
        w = eff_width(reg_w);
        if (pos_row == 0 && pos_col == 0)
            return 1'b1;
        for (int k = 0; k < w; k++)
            if (!(above_seen[k] && current_seen[k]))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [7:0] pick_cell_value();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------

    task automatic apb_transfer(input bit is_write, input logic [2:0] addr,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_reg(input logic idx);
        logic [31:0] readback;
        logic [31:0] want;
        apb_transfer(1'b0, {idx, 2'b00}, 32'd0, readback);
        want = (idx == bfem_pkg::REG_FRAME_WIDTH) ? {24'd0, cfg_width} : {25'd0, cfg_height};
        if (readback !== want)
            note_failure($sformatf("register %0d readback: expected %0d, got %0d",
                                   idx, want, readback));
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        logic [31:0] word;
        logic [31:0] unused;
        word       = $urandom;
        word[7:0]  = value;
        apb_transfer(1'b1, {idx, 2'b00}, word, unused);
        if (idx == bfem_pkg::REG_FRAME_WIDTH)
            cfg_width = word[7:0];
        else
            cfg_height = word[6:0];
        check_reg(idx);
    endtask

    // ------------------------------------------------------------------
    // stream side
    // ------------------------------------------------------------------

    // one input transfer, with an optional gap ahead of it
    task automatic send_cell(input logic [7:0] value);
        int unsigned gap;
        gap = sender_idles ? $urandom_range(0, 14) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        smooth_cell(value);
    endtask

    // stop offering cells until every queued mean has left the block
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_means.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_geometry(input logic [7:0] w_reg, input logic [7:0] h_reg);
        wait_idle();
        write_reg(bfem_pkg::REG_FRAME_WIDTH, w_reg);
        write_reg(bfem_pkg::REG_FRAME_HEIGHT, h_reg);
    endtask

    // receiver: random ready gaps and a long hold-off on request
    initial
    begin
        int unsigned gap;
        m_tready = 1'b0;
        forever
        begin
            if (ready_holdoff != 0)
            begin
                m_tready <= 1'b0;
                repeat (ready_holdoff) @(posedge clk);
                ready_holdoff = 0;
            end
            else
            begin
                gap = receiver_idles ? $urandom_range(0, 14) : 0;
                if (gap != 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                m_tready <= 1'b1;
                do
                    @(posedge clk);
                while (!m_tvalid && ready_holdoff == 0);
            end
        end
    end

    // output check against the oldest queued mean
    task automatic check_mean();
        mean_result_t want;
        mean_result_t got;
        got.row  = m_tdata[5:0];
        got.col  = m_tdata[12:6];
        got.mean = m_tdata[20:13];
        got.last = m_tlast;
        if (expected_means.size() == 0)
        begin
            note_failure($sformatf("unexpected result: row %0d col %0d mean %0d last %0d",
                                   got.row, got.col, got.mean, got.last));
        end
        else
        begin
            want = expected_means.pop_front();
            if (got.row !== want.row || got.col !== want.col ||
                got.mean !== want.mean || got.last !== want.last)
                note_failure($sformatf({"mismatch: expected row %0d col %0d mean %0d last %0d,",
                                        " got row %0d col %0d mean %0d last %0d"},
                                       want.row, want.col, want.mean, want.last,
                                       got.row, got.col, got.mean, got.last));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_mean();
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_reset_values();
        check_reg(bfem_pkg::REG_FRAME_WIDTH);
        check_reg(bfem_pkg::REG_FRAME_HEIGHT);
    endtask

    // corners, edges and centre of a 3x3 frame; the first row completes nothing
    task automatic test_full_window();
        logic [7:0] cells [9] = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255,
                                  8'd0, 8'd255, 8'd0, 8'd255};
        set_geometry(8'd3, 8'd3);
        foreach (cells[k])
            send_cell(cells[k]);
    endtask

    // one-column and one-row frames
    task automatic test_thin_frames();
        logic [7:0] column_cells [4] = '{8'd255, 8'd255, 8'd1, 8'd254};
        logic [7:0] row_cells    [4] = '{8'd0, 8'd255, 8'd128, 8'd127};
        set_geometry(8'd1, 8'd4);
        foreach (column_cells[k])
            send_cell(column_cells[k]);
        set_geometry(8'd4, 8'd1);
        foreach (row_cells[k])
            send_cell(row_cells[k]);
    endtask

    // zero geometry is used as a single cell frame
    task automatic test_clamped_geometry();
        set_geometry(8'd0, 8'd0);
        send_cell(8'd255);
        send_cell(8'd0);
    endtask

    // width beyond the limit is used as the widest row
    task automatic test_widest_row();
        set_geometry(8'd255, 8'd0);
        repeat (MAX_W)
        begin
            send_cell(pick_cell_value());
            random_cells = random_cells + 1;
        end
    endtask

    // height beyond the limit is used as the tallest column
    task automatic test_tallest_column();
        set_geometry(8'd1, 8'd127);
        repeat (MAX_H)
        begin
            send_cell(pick_cell_value());
            random_cells = random_cells + 1;
        end
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        set_geometry(8'd6, 8'd4);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        ready_holdoff  = 300;
        repeat (24)
        begin
            send_cell(pick_cell_value());
            random_cells = random_cells + 1;
        end
        wait_idle();
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    // pause mid-frame, and sometimes change the geometry there
    task automatic midframe_change();
        logic [7:0] w_reg;
        wait_idle();
        if ($urandom_range(0, 2) != 0)
        begin
            w_reg = $urandom_range(0, 7);
            if (width_is_safe(w_reg))
                write_reg(bfem_pkg::REG_FRAME_WIDTH, w_reg);
            write_reg(bfem_pkg::REG_FRAME_HEIGHT, 8'($urandom_range(0, 5)));
        end
    endtask

    // small random frames with random gaps on both sides
    task automatic test_random_frames();
        logic [7:0]  w_reg;
        logic [7:0]  h_reg;
        int unsigned span;
        int unsigned change_at;
        int unsigned sent;
        int          frames;
        frames = 0;
        while (random_cells < RANDOM_CELLS || frames < 8)
        begin
            w_reg = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
            h_reg = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 4));
            set_geometry(w_reg, h_reg);
            sender_idles   = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
            span = eff_width(w_reg) * eff_height(h_reg[6:0]);
            change_at = (span > 1 && $urandom_range(0, 2) == 0) ? $urandom_range(1, span - 1) : 0;
            sent = 0;
            do
            begin
                if (change_at != 0 && sent == change_at)
                    midframe_change();
                send_cell(pick_cell_value());
                sent = sent + 1;
                random_cells = random_cells + 1;
            end
            while (pos_row != 0 || pos_col != 0);
            frames = frames + 1;
        end
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = 3'd0;
        pwdata   = 32'd0;
        clear_filter_state();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_full_window();
        test_thin_frames();
        test_clamped_geometry();
        test_widest_row();
        test_tallest_column();
        test_backpressure();
        test_random_frames();
        wait_idle();

        if (mismatch_count == 0 && expected_means.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
src/bfem_pkg.sv
src/box_filter_3x3_edge_mean_top.sv
verif/testbench.sv
